FILE: rtl/mmpi_pkg.sv
// Shared types and constants for the multi-motor incremental PI controller.
package mmpi_pkg;

  // Field widths
  localparam int unsigned MOTOR_W = 2;
  localparam int unsigned SPEED_W = 24;
  localparam int unsigned ERR_W   = 25;
  localparam int unsigned DELTA_W = 26;
  localparam int unsigned GAIN_W  = 32;
  localparam int unsigned LIMIT_W = 15;
  localparam int unsigned MASK_W  = 4;
  localparam int unsigned ACC_W   = 32;
  localparam int unsigned DRIVE_W = 16;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned PKP_W   = GAIN_W + 1 + DELTA_W;
  localparam int unsigned PKI_W   = GAIN_W + 1 + ERR_W;
  localparam int unsigned INC_W   = PKP_W - FRAC_W;
  localparam int unsigned WIDE_W  = INC_W + 1;
  localparam int unsigned CFG_W   = 32;

  // Register reset values
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd10000;
  localparam logic [MASK_W-1:0]  MASK_RESET  = 4'd12;

  // Register indexes
  typedef enum logic [1:0] {
    CFG_KP    = 2'd0,
    CFG_KI    = 2'd1,
    CFG_LIMIT = 2'd2,
    CFG_MASK  = 2'd3
  } cfg_idx_e;

  // One input item held in the input register
  typedef struct packed {
    logic [MOTOR_W-1:0]        motor;
    logic signed [SPEED_W-1:0] measured;
    logic signed [SPEED_W-1:0] target;
  } sample_t;

  // Products handed from the error stage to the accumulator stage
  typedef struct packed {
    logic                    motor_ok;
    logic [MOTOR_W-1:0]      motor;
    logic signed [PKP_W-1:0] p_kp;
    logic signed [PKI_W-1:0] p_ki;
  } prod_t;

endpackage

FILE: rtl/multi_motor_incremental_pi.sv
// Incremental PI speed controller for several motors. Each sample item names a
// motor and carries measured and target speed (signed Q8.16); one drive value
// item comes back per sample, via the input, product and drive registers. A new
// sample is taken every cycle unless the output side stalls: the per-motor last
// error is updated in the product stage and the per-motor accumulator in the
// final stage, each read and written in the same stage, so samples for the same
// motor may follow each other directly. Configuration (gains, limit, invert
// mask) is to be written by the user while no item is in flight; the block does
// not enforce it. Indexes are 0 kp, 1 ki, 2 output limit, 3 invert mask.
module multi_motor_incremental_pi import mmpi_pkg::*; #(
  parameter int unsigned NUM_MOTORS = 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [CFG_W-1:0]          cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [MOTOR_W-1:0]        motor_index_i,
  input  logic signed [SPEED_W-1:0] measured_speed_i,
  input  logic signed [SPEED_W-1:0] target_speed_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [DRIVE_W-1:0] drive_value_o
);

  logic [GAIN_W-1:0]  kp_q;
  logic [GAIN_W-1:0]  ki_q;
  logic [LIMIT_W-1:0] limit_q;
  logic [MASK_W-1:0]  mask_q;

  sample_t s0_q;
  logic    s0_valid_q, s0_valid_d;
  logic    s1_valid_q, s1_valid_d;
  logic    out_valid_q, out_valid_d;
  logic    s2_free, s1_free, s1_adv, s0_adv, in_acc;
  prod_t   prod;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q    <= '0;
      ki_q    <= '0;
      limit_q <= LIMIT_RESET;
      mask_q  <= MASK_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_KP:    kp_q    <= cfg_wdata_i;
        CFG_KI:    ki_q    <= cfg_wdata_i;
        CFG_LIMIT: limit_q <= cfg_wdata_i[LIMIT_W-1:0];
        CFG_MASK:  mask_q  <= cfg_wdata_i[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance each stage when the one after it has room
  always_comb begin
    s2_free    = !out_valid_q || out_ready_i;
    s1_adv     = s1_valid_q && s2_free;
    s1_free    = !s1_valid_q || s2_free;
    s0_adv     = s0_valid_q && s1_free;
    in_ready_o = !s0_valid_q || s1_free;
    in_acc     = in_valid_i && in_ready_o;

    s0_valid_d  = in_acc ? 1'b1 : (s0_adv ? 1'b0 : s0_valid_q);
    s1_valid_d  = s0_adv ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);
    out_valid_d = s1_adv ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s0_valid_q  <= s0_valid_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the input item
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s0_q.motor    <= motor_index_i;
      s0_q.measured <= measured_speed_i;
      s0_q.target   <= target_speed_i;
    end
  end

  mmpi_err_stage #(
    .NUM_MOTORS(NUM_MOTORS)
  ) u_err (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (s0_adv),
    .sample_i     (s0_q),
    .kp_i         (kp_q),
    .ki_i         (ki_q),
    .invert_mask_i(mask_q),
    .prod_o       (prod)
  );

  mmpi_acc_stage #(
    .NUM_MOTORS(NUM_MOTORS)
  ) u_acc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (s1_adv),
    .prod_i (prod),
    .limit_i(limit_q),
    .drive_o(drive_value_o)
  );

  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/mmpi_err_stage.sv
// Error stage: per-motor error, change in error, and both gain products.
module mmpi_err_stage import mmpi_pkg::*; #(
  parameter int unsigned NUM_MOTORS = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  sample_t           sample_i,
  input  logic [GAIN_W-1:0] kp_i,
  input  logic [GAIN_W-1:0] ki_i,
  input  logic [MASK_W-1:0] invert_mask_i,
  output prod_t             prod_o
);

  localparam int unsigned NUM_CH = (NUM_MOTORS < 4) ? NUM_MOTORS : 4;
  localparam int unsigned CH_W   = (NUM_CH > 1) ? $clog2(NUM_CH) : 1;

  logic signed [ERR_W-1:0] prev_q [NUM_CH];
  prod_t                   prod_q;

  logic                    motor_ok;
  logic [CH_W-1:0]         ch;
  logic signed [ERR_W-1:0] meas;
  logic signed [ERR_W-1:0] meas_n;
  logic signed [DELTA_W-1:0] err_w;
  logic signed [ERR_W-1:0] err;
  logic signed [DELTA_W-1:0] delta;
  logic signed [GAIN_W:0]  kp_s;
  logic signed [GAIN_W:0]  ki_s;
  prod_t                   prod_d;

  // Form error and change in error for the addressed motor
  always_comb begin
    motor_ok = ({1'b0, sample_i.motor} < 3'(NUM_CH));
    ch       = sample_i.motor[CH_W-1:0];
    meas     = {sample_i.measured[SPEED_W-1], sample_i.measured};
    meas_n   = invert_mask_i[sample_i.motor] ? -meas : meas;
    err_w    = {{2{sample_i.target[SPEED_W-1]}}, sample_i.target}
             - {meas_n[ERR_W-1], meas_n};
    err      = err_w[ERR_W-1:0];
    delta    = {err[ERR_W-1], err} - {prev_q[ch][ERR_W-1], prev_q[ch]};
    kp_s     = {1'b0, kp_i};
    ki_s     = {1'b0, ki_i};
    prod_d.motor_ok = motor_ok;
    prod_d.motor    = sample_i.motor;
    prod_d.p_kp     = kp_s * delta;
    prod_d.p_ki     = ki_s * err;
  end

  // Store the last error of each motor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CH; i++) begin
        prev_q[i] <= '0;
      end
    end else if (adv_i && motor_ok) begin
      prev_q[ch] <= err;
    end
  end

  // Register the products
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

FILE: rtl/mmpi_acc_stage.sv
// Accumulator stage: anti-windup increment, clamp, and drive truncation.
module mmpi_acc_stage import mmpi_pkg::*; #(
  parameter int unsigned NUM_MOTORS = 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  prod_t                     prod_i,
  input  logic [LIMIT_W-1:0]        limit_i,
  output logic signed [DRIVE_W-1:0] drive_o
);

  localparam int unsigned NUM_CH = (NUM_MOTORS < 4) ? NUM_MOTORS : 4;
  localparam int unsigned CH_W   = (NUM_CH > 1) ? $clog2(NUM_CH) : 1;

  logic signed [ACC_W-1:0]   acc_q [NUM_CH];
  logic signed [DRIVE_W-1:0] drive_q;

  logic [CH_W-1:0]           ch;
  logic signed [PKP_W-1:0]   sum;
  logic signed [INC_W-1:0]   inc;
  logic signed [WIDE_W-1:0]  inc_w;
  logic signed [WIDE_W-1:0]  acc_w;
  logic signed [WIDE_W-1:0]  lim;
  logic signed [WIDE_W-1:0]  nlim;
  logic                      blocked;
  logic signed [WIDE_W-1:0]  nxt;
  logic signed [ACC_W-1:0]   acc_new;
  logic [ACC_W-1:0]          mag;
  logic [DRIVE_W-1:0]        mag_int;
  logic signed [DRIVE_W-1:0] drive_d;

  // Increment, blocked at a limit in its direction, then clamp
  always_comb begin
    ch    = prod_i.motor[CH_W-1:0];
    sum   = prod_i.p_kp + {prod_i.p_ki[PKI_W-1], prod_i.p_ki};
    inc   = sum[PKP_W-1:FRAC_W];
    inc_w = {inc[INC_W-1], inc};
    acc_w = {{(WIDE_W-ACC_W){acc_q[ch][ACC_W-1]}}, acc_q[ch]};
    lim   = {{(WIDE_W-LIMIT_W-FRAC_W){1'b0}}, limit_i, {FRAC_W{1'b0}}};
    nlim  = -lim;
    blocked = ((acc_w >= lim) && !inc[INC_W-1] && (inc != '0))
           || ((acc_w <= nlim) && inc[INC_W-1]);
    nxt = acc_w + (blocked ? '0 : inc_w);
    if (nxt > lim) begin
      nxt = lim;
    end else if (nxt < nlim) begin
      nxt = nlim;
    end
    acc_new = nxt[ACC_W-1:0];
    // Truncate the integer part toward zero
    mag     = acc_new[ACC_W-1] ? ACC_W'(-acc_new) : ACC_W'(acc_new);
    mag_int = mag[ACC_W-1:FRAC_W];
    if (!prod_i.motor_ok) begin
      drive_d = '0;
    end else if (acc_new[ACC_W-1]) begin
      drive_d = -$signed(mag_int);
    end else begin
      drive_d = $signed(mag_int);
    end
  end

  // Store the accumulator of each motor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CH; i++) begin
        acc_q[i] <= '0;
      end
    end else if (adv_i && prod_i.motor_ok) begin
      acc_q[ch] <= acc_new;
    end
  end

  // Hold the result
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      drive_q <= drive_d;
    end
  end

  assign drive_o = drive_q;

endmodule

FILE: rtl/mmpi_checker.sv
// Port-level checks for the multi-motor incremental PI controller.
module mmpi_checker import mmpi_pkg::*; (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic signed [DRIVE_W-1:0] drive_value_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(drive_value_o))
    else $error("stalled drive value changed or dropped");

  // Clamp keeps the drive inside the symmetric range
  a_drive_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> drive_value_o != 16'sh8000)
    else $error("drive value outside symmetric range");

  // Take items whenever the output side drains
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ready_i || !out_valid_o) |-> in_ready_o)
    else $error("input stalled while output side free");

  // Deliver an accepted item when the output side takes items meanwhile
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) ##1 out_ready_i ##1 out_ready_i |=> out_valid_o)
    else $error("accepted item did not reach the output");

endmodule

bind multi_motor_incremental_pi mmpi_checker u_mmpi_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .drive_value_o(drive_value_o)
);

FILE: verif/multi_motor_incremental_pi_test.sv
// Self-checking testbench for the four-motor incremental PI drive controller.
module multi_motor_incremental_pi_test import mmpi_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MOTORS = 4;
  localparam int unsigned PHASE_ITEMS = 230;
  localparam logic signed [SPEED_W-1:0] SPEED_MIN = 24'h800000;
  localparam logic signed [SPEED_W-1:0] SPEED_MAX = 24'h7FFFFF;
  localparam logic [GAIN_W-1:0] GAIN_MAX = 32'hFFFF_FFFF;
  localparam logic [GAIN_W-1:0] GAIN_ONE = 32'h0001_0000;

  // Mirror of the controller: per-motor error history and accumulator
  class pi_drive_tracker;
    logic [GAIN_W-1:0]         kp;
    logic [GAIN_W-1:0]         ki;
    logic [LIMIT_W-1:0]        limit;
    logic [MASK_W-1:0]         mask;
    logic signed [ERR_W-1:0]   last_err [MOTORS];
    logic signed [ACC_W-1:0]   accum [MOTORS];
    logic signed [DRIVE_W-1:0] drive_due [$];
    int                        fault_count;

    function new();
      kp = '0;
      ki = '0;
      limit = LIMIT_RESET;
      mask = MASK_RESET;
      fault_count = 0;
      for (int m = 0; m < MOTORS; m++) begin
        last_err[m] = '0;
        accum[m] = '0;
      end
    endfunction

    function void set_register(cfg_idx_e idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_KP:    kp = data;
        CFG_KI:    ki = data;
        CFG_LIMIT: limit = data[LIMIT_W-1:0];
        CFG_MASK:  mask = data[MASK_W-1:0];
        default: ;
      endcase
    endfunction

    // Advance one motor's state and queue the drive value it yields
    function void take_sample(logic [MOTOR_W-1:0] m, logic signed [SPEED_W-1:0] meas,
                              logic signed [SPEED_W-1:0] targ);
      longint meas_l, targ_l, err, delta, inc, acc, lim, kp_l, ki_l, drv;
      if (m >= MOTORS) begin
        drive_due.push_back('0);
        return;
      end
      meas_l = meas;
      targ_l = targ;
      kp_l = kp;
      ki_l = ki;
      lim = limit;
      lim = lim * 65536;
      if (m < 4 && mask[m]) meas_l = -meas_l;
      err = targ_l - meas_l;
      delta = err - longint'(last_err[m]);
      // floor of the Q16.16 product sum
      inc = (kp_l * delta + ki_l * err) >>> FRAC_W;
      acc = accum[m];
      // hold the accumulator when it already sits at the limit in that direction
      if (acc >= lim && inc > 0) inc = 0;
      if (acc <= -lim && inc < 0) inc = 0;
      acc = acc + inc;
      if (acc > lim) acc = lim;
      if (acc < -lim) acc = -lim;
      accum[m] = acc[ACC_W-1:0];
      last_err[m] = err[ERR_W-1:0];
      // integer part, truncated toward zero
      if (acc < 0) drv = -((-acc) >>> FRAC_W);
      else drv = acc >>> FRAC_W;
      drive_due.push_back(drv[DRIVE_W-1:0]);
    endfunction

    task log_fault(string what);
      $display("%0t ns: %s", $time, what);
      fault_count++;
    endtask

    task check_drive(logic signed [DRIVE_W-1:0] got);
      logic signed [DRIVE_W-1:0] want;
      if (drive_due.size() == 0) begin
        log_fault($sformatf("drive value %0d with no sample waiting", got));
      end else begin
        want = drive_due.pop_front();
        if (got !== want)
          log_fault($sformatf("drive_value got %0d expected %0d", got, want));
      end
    endtask

    function int pending();
      return drive_due.size();
    endfunction
  endclass

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [1:0]                cfg_idx_i;
  logic [CFG_W-1:0]          cfg_wdata_i;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic [MOTOR_W-1:0]        motor_index_i;
  logic signed [SPEED_W-1:0] measured_speed_i;
  logic signed [SPEED_W-1:0] target_speed_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic signed [DRIVE_W-1:0] drive_value_o;

  pi_drive_tracker board;
  int              idle_pct;

  multi_motor_incremental_pi #(
    .NUM_MOTORS(MOTORS)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .motor_index_i   (motor_index_i),
    .measured_speed_i(measured_speed_i),
    .target_speed_i  (target_speed_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .drive_value_o   (drive_value_o)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Take drive values and stall the output side at random
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) board.check_drive(drive_value_o);
    out_ready_i <= ($urandom_range(99) >= idle_pct);
  end

  // Present one sample item, with random gaps, and hold it until taken
  task automatic send_sample(input logic [MOTOR_W-1:0] m, input logic signed [SPEED_W-1:0] meas,
                             input logic signed [SPEED_W-1:0] targ);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    motor_index_i <= m;
    measured_speed_i <= meas;
    target_speed_i <= targ;
    do @(posedge clk_i); while (!in_ready_o);
    board.take_sample(m, meas, targ);
  endtask

  // Stop sending and wait for every outstanding drive value
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    board.set_register(idx, data);
  endtask

  task automatic apply_settings(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                                input logic [LIMIT_W-1:0] lim, input logic [MASK_W-1:0] mask);
    write_reg(CFG_KP, kp);
    write_reg(CFG_KI, ki);
    write_reg(CFG_LIMIT, CFG_W'(lim));
    write_reg(CFG_MASK, CFG_W'(mask));
    cfg_we_i <= 1'b0;
  endtask

  // Speeds of every magnitude, with the extremes now and then
  function automatic logic signed [SPEED_W-1:0] pick_speed();
    int raw;
    raw = $urandom;
    case ($urandom_range(9))
      0: return SPEED_MIN;
      1: return SPEED_MAX;
      default: return SPEED_W'(raw >>> $urandom_range(8, 31));
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    logic [GAIN_W-1:0] g;
    g = $urandom;
    return g >> $urandom_range(0, 31);
  endfunction

  function automatic logic [LIMIT_W-1:0] pick_limit();
    logic [LIMIT_W-1:0] v;
    v = LIMIT_W'($urandom_range(1, 32767) >> $urandom_range(0, 14));
    return (v == '0) ? LIMIT_W'(1) : v;
  endfunction

  initial begin
    logic [GAIN_W-1:0]  kp_set, ki_set;
    logic [LIMIT_W-1:0] lim_set;
    logic [MASK_W-1:0]  mask_set;
    logic [MOTOR_W-1:0] motor;

    board = new();
    idle_pct = 35;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_KP;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    motor_index_i = '0;
    measured_speed_i = '0;
    target_speed_i = '0;
    out_ready_i = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: zero gains leave the drive at zero but load the error history
    for (int m = 0; m < MOTORS; m++) send_sample(MOTOR_W'(m), SPEED_MIN, SPEED_MAX);

    // Unit proportional gain, quarter integral gain, default invert mask: opposite extremes on every motor
    drain_results();
    apply_settings(GAIN_ONE, GAIN_ONE >> 2, 15'd10000, 4'd12);
    for (int m = 0; m < MOTORS; m++) begin
      send_sample(MOTOR_W'(m), SPEED_MIN, SPEED_MAX);
      send_sample(MOTOR_W'(m), SPEED_MAX, SPEED_MIN);
      send_sample(MOTOR_W'(m), '0, '0);
    end

    // Full gains, limit of one: saturate, stay blocked, swing to the other side
    drain_results();
    apply_settings(GAIN_MAX, GAIN_MAX, 15'd1, 4'd15);
    repeat (3) send_sample(2'd0, '0, SPEED_MAX);
    repeat (2) send_sample(2'd0, '0, SPEED_MIN);
    send_sample(2'd0, '0, '0);

    // Zero limit pins the accumulator at zero
    drain_results();
    apply_settings(GAIN_MAX, GAIN_ONE, 15'd0, 4'd0);
    send_sample(2'd1, SPEED_MIN, SPEED_MAX);
    send_sample(2'd1, SPEED_MAX, SPEED_MIN);
    send_sample(2'd2, 24'sd12345, -24'sd777);

    // Random phases, each with its own settings
    motor = '0;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          kp_set = GAIN_MAX; ki_set = GAIN_MAX; lim_set = 15'd32767; mask_set = 4'd15;
        end
        1: begin
          kp_set = '0; ki_set = 32'd1; lim_set = 15'd1; mask_set = 4'd0;
        end
        default: begin
          kp_set = pick_gain(); ki_set = pick_gain();
          lim_set = pick_limit(); mask_set = MASK_W'($urandom);
        end
      endcase
      drain_results();
      apply_settings(kp_set, ki_set, lim_set, mask_set);
      idle_pct = (ph == 4) ? 0 : 35;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 2 && n == PHASE_ITEMS / 2) drain_results();
        // keep hitting the same motor now and then
        if ($urandom_range(3) != 0) motor = MOTOR_W'($urandom);
        send_sample(motor, pick_speed(), pick_speed());
      end
    end

    drain_results();
    repeat (10) @(posedge clk_i);
    if (board.fault_count == 0 && board.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #1ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
